// ===== rtl/core/pdwf_pkg.sv =====
// Shared types, codes and constants for the wall-follow obstacle controller.
package pdwf_pkg;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = 2;
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = 3;

  typedef enum logic [2:0] {
    REG_OP_MODE       = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_I        = 3'd2,
    REG_GAIN_D        = 3'd3,
    REG_FRONT_STOP    = 3'd4,
    REG_DYNAMIC_STOP  = 3'd5,
    REG_APPROACH_LIM  = 3'd6,
    REG_MAX_VALID     = 3'd7
  } reg_index_t;

  localparam logic [1:0] MODE_INVALID  = 2'd0;
  localparam logic [1:0] MODE_STRAIGHT = 2'd1;
  localparam logic [1:0] MODE_ZIGZAG   = 2'd2;
  localparam logic [1:0] MODE_DYNAMIC  = 2'd3;

  localparam logic [2:0] ACT_FOLLOW       = 3'd0;
  localparam logic [2:0] ACT_ESCAPE_LEFT  = 3'd1;
  localparam logic [2:0] ACT_ESCAPE_RIGHT = 3'd2;
  localparam logic [2:0] ACT_STOP_HOLD    = 3'd3;
  localparam logic [2:0] ACT_RESUME       = 3'd4;
  localparam logic [2:0] ACT_INVALID      = 3'd5;

  localparam logic [10:0] STEER_CENTRE     = 11'd1500;
  localparam logic [10:0] STEER_FULL_LEFT  = 11'd2000;
  localparam logic [10:0] STEER_FULL_RIGHT = 11'd1000;
  localparam logic [10:0] STEER_SOFT_LEFT  = 11'd1750;
  localparam logic [10:0] STEER_SOFT_RIGHT = 11'd1250;

  localparam logic [4:0] MOTOR_OFF   = 5'd0;
  localparam logic [4:0] MOTOR_CREEP = 5'd7;
  localparam logic [4:0] MOTOR_SLOW  = 5'd10;
  localparam logic [4:0] MOTOR_FAST  = 5'd20;

  // 1000 mm in Q12.4
  localparam logic [15:0] FILTER_RESET = 16'd16000;
  // floor(x/5) = (x * 419431) >> 21, exact for x below 699050
  localparam logic [18:0] DIV5_RECIP = 19'd419431;

  localparam logic signed [9:0]  PD_SUM_LIM = 10'sd400;
  localparam logic signed [26:0] PD_ACC_LIM = 27'sd102400;

  typedef struct packed {
    logic [1:0]  op_mode;
    logic [9:0]  gain_p;
    logic [9:0]  gain_i;
    logic [9:0]  gain_d;
    logic [11:0] static_stop_mm;
    logic [11:0] dynamic_stop_mm;
    logic [11:0] approach_limit_mm;
    logic [11:0] max_valid_mm;
  } cfg_t;

  // classified tick, front to back
  typedef struct packed {
    logic        run_pd;
    logic        clear_mem;
    logic        dbl;
    logic        go_left;
    logic [10:0] steer;
    logic [4:0]  fwd;
    logic [4:0]  rev;
    logic [2:0]  action;
    logic        hold;
    logic [11:0] left_mm;
    logic [11:0] right_mm;
    logic [11:0] filt_mm;
  } cmd_t;

  // one result queue word; dbl expands into a stop word and a resume word
  typedef struct packed {
    logic [10:0]        steer;
    logic [4:0]         fwd;
    logic [4:0]         rev;
    logic [2:0]         action;
    logic               hold;
    logic signed [9:0]  corr;
    logic [11:0]        filt_mm;
    logic               dbl;
    logic               go_left;
  } res_t;

  function automatic logic [11:0] side_mm(input logic [9:0] cm, input logic [11:0] max_mm);
    logic [13:0] mm;
    mm = {1'b0, cm, 3'b000} + {3'b000, cm, 1'b0};
    if (mm == 14'd0 || mm > {2'b00, max_mm}) begin
      return max_mm;
    end
    return mm[11:0];
  endfunction

endpackage

// ===== rtl/core/pdwf_front.sv =====
// Front end: takes sensor words, runs the range filter and classifies each tick.
module pdwf_front import pdwf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             push,
  output logic             full,
  input  logic [15:0]      front_raw_mm,
  input  logic [9:0]       left_echo_cm,
  input  logic [9:0]       right_echo_cm,
  input  logic [CQ_AW:0]   cq_count,
  output logic             cq_push,
  output cmd_t             cq_wdata
);

  logic        accept;
  logic        raw_ok;
  logic [15:0] raw_q;
  logic [18:0] filt_sum;
  logic [37:0] filt_prod;
  logic [15:0] filt_new;

  logic        filter;
  logic [15:0] filt;
  logic [15:0] front_prev;
  logic        a_v;
  logic [15:0] a_filt;
  logic [11:0] a_left;
  logic [11:0] a_right;

  logic        go_left;
  logic        near_static;
  logic        near_dyn;
  logic        closing;

  // a stage-A word always has a queue slot reserved
  assign full   = ({1'b0, cq_count} + {3'b000, a_v}) >= 4'(CQ_DEPTH);
  assign accept = push && !full;
  assign filter = accept;

  assign raw_ok    = (front_raw_mm != 16'd0) && (front_raw_mm <= {4'b0000, cfg.max_valid_mm});
  assign raw_q     = raw_ok ? {front_raw_mm[11:0], 4'b0000} : filt;
  assign filt_sum  = {3'b000, filt} + {1'b0, raw_q, 2'b00} + 19'd2;
  assign filt_prod = 38'(filt_sum) * 38'(DIV5_RECIP);
  assign filt_new  = filt_prod[36:21];

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= FILTER_RESET;
      a_v  <= 1'b0;
    end else begin
      a_v <= accept;
      if (filter) begin
        filt <= filt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_filt  <= filt_new;
      a_left  <= side_mm(left_echo_cm, cfg.max_valid_mm);
      a_right <= side_mm(right_echo_cm, cfg.max_valid_mm);
    end
  end

  assign go_left     = a_left > a_right;
  assign near_static = a_filt < {cfg.static_stop_mm, 4'b0000};
  assign near_dyn    = a_filt < {cfg.dynamic_stop_mm, 4'b0000};
  assign closing     = (front_prev > a_filt) &&
                       ((front_prev - a_filt) > {cfg.approach_limit_mm, 4'b0000});

  always_comb begin
    cq_wdata           = '0;
    cq_wdata.go_left   = go_left;
    cq_wdata.left_mm   = a_left;
    cq_wdata.right_mm  = a_right;
    cq_wdata.filt_mm   = a_filt[15:4];
    cq_wdata.steer     = STEER_CENTRE;
    cq_wdata.fwd       = MOTOR_OFF;
    cq_wdata.rev       = MOTOR_OFF;
    cq_wdata.action    = ACT_INVALID;
    case (cfg.op_mode)
      MODE_STRAIGHT, MODE_ZIGZAG: begin
        if (near_static) begin
          cq_wdata.clear_mem = 1'b1;
          cq_wdata.rev       = MOTOR_CREEP;
          cq_wdata.action    = go_left ? ACT_ESCAPE_LEFT : ACT_ESCAPE_RIGHT;
          if (cfg.op_mode == MODE_STRAIGHT) begin
            cq_wdata.steer = go_left ? STEER_SOFT_LEFT : STEER_SOFT_RIGHT;
          end else begin
            cq_wdata.steer = go_left ? STEER_FULL_LEFT : STEER_FULL_RIGHT;
          end
        end else begin
          cq_wdata.run_pd = 1'b1;
          cq_wdata.action = ACT_FOLLOW;
          cq_wdata.fwd    = (cfg.op_mode == MODE_STRAIGHT) ? MOTOR_FAST : MOTOR_SLOW;
        end
      end
      MODE_DYNAMIC: begin
        if (near_dyn || closing) begin
          cq_wdata.clear_mem = 1'b1;
          cq_wdata.dbl       = 1'b1;
          cq_wdata.hold      = 1'b1;
          cq_wdata.action    = ACT_STOP_HOLD;
        end else begin
          cq_wdata.run_pd = 1'b1;
          cq_wdata.action = ACT_FOLLOW;
          cq_wdata.fwd    = MOTOR_SLOW;
        end
      end
      default: begin
        cq_wdata.action = ACT_INVALID;
      end
    endcase
  end

  assign cq_push = a_v;

  // approach rate tracks only in the dynamic mode
  always_ff @(posedge clk) begin
    if (rst) begin
      front_prev <= FILTER_RESET;
    end else if (a_v && cfg.op_mode == MODE_DYNAMIC) begin
      front_prev <= a_filt;
    end
  end

endmodule

// ===== rtl/core/pdwf_cmd_q.sv =====
// Short queue of classified ticks between the front end and the controller.
module pdwf_cmd_q import pdwf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cmd_t           wdata,
  input  logic           pop,
  output cmd_t           rdata,
  output logic [CQ_AW:0] count,
  output logic           empty
);

  cmd_t             mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;

  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (CQ_AW+1)'(push) - (CQ_AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/pdwf_back.sv =====
// Back end: PD controller pipeline, result queue and stop/resume expansion.
module pdwf_back import pdwf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               cq_empty,
  input  cmd_t               cmd,
  output logic               cq_pop,
  output logic               empty,
  input  logic               pop,
  output logic [10:0]        steer_us,
  output logic [4:0]         forward_ms,
  output logic [4:0]         reverse_ms,
  output logic [2:0]         action,
  output logic               hold_pause,
  output logic signed [9:0]  correction_us,
  output logic [11:0]        front_filtered_mm,
  output logic               last
);

  logic signed [9:0]  err_sum;
  logic signed [12:0] err_prev;

  logic signed [12:0] e;
  logic signed [13:0] sum_raw;
  logic signed [9:0]  sum_sat;
  logic signed [13:0] d;

  logic               s1_v;
  cmd_t               s1_cmd;
  logic signed [12:0] s1_e;
  logic signed [9:0]  s1_sum;
  logic signed [13:0] s1_d;

  logic               s2_v;
  cmd_t               s2_cmd;
  logic signed [24:0] s2_pp;
  logic signed [24:0] s2_pi;
  logic signed [24:0] s2_pd;

  logic signed [26:0] acc;
  logic signed [26:0] acc_sat;
  logic signed [26:0] acc_div;

  logic               s3_v;
  cmd_t               s3_cmd;
  logic signed [9:0]  s3_corr;

  logic signed [11:0] steer_s;
  res_t               rq_wdata;
  res_t               rq_mem [RQ_DEPTH];
  res_t               head;
  logic [RQ_AW-1:0]   rq_wr;
  logic [RQ_AW-1:0]   rq_rd;
  logic [RQ_AW:0]     rq_count;
  logic               rq_pop;
  logic               phase;
  logic [RQ_AW+1:0]   inflight;

  // every word in the pipe has a result slot reserved
  assign inflight = {1'b0, rq_count} + (RQ_AW+2)'(s1_v) + (RQ_AW+2)'(s2_v)
                  + (RQ_AW+2)'(s3_v);
  assign cq_pop   = !cq_empty && (inflight < (RQ_AW+2)'(RQ_DEPTH));

  // stage 1: error terms and controller memory
  assign e       = $signed({1'b0, cmd.left_mm}) - $signed({1'b0, cmd.right_mm});
  assign sum_raw = 14'(err_sum) + 14'(e);
  assign d       = 14'(e) - 14'(err_prev);

  always_comb begin
    if (sum_raw > 14'(PD_SUM_LIM)) begin
      sum_sat = PD_SUM_LIM;
    end else if (sum_raw < -14'(PD_SUM_LIM)) begin
      sum_sat = -PD_SUM_LIM;
    end else begin
      sum_sat = sum_raw[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_sum  <= '0;
      err_prev <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
    end else begin
      s1_v <= cq_pop;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (cq_pop) begin
        if (cmd.clear_mem) begin
          err_sum  <= '0;
          err_prev <= '0;
        end else if (cmd.run_pd) begin
          err_sum  <= sum_sat;
          err_prev <= e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd <= cmd;
    s1_e   <= e;
    s1_sum <= sum_sat;
    s1_d   <= d;
    // stage 2: the three gain products
    s2_cmd <= s1_cmd;
    s2_pp  <= 25'($signed({1'b0, cfg.gain_p})) * 25'(s1_e);
    s2_pi  <= 25'($signed({1'b0, cfg.gain_i})) * 25'(s1_sum);
    s2_pd  <= 25'($signed({1'b0, cfg.gain_d})) * 25'(s1_d);
    // stage 3: sum, clamp, scale
    s3_cmd  <= s2_cmd;
    s3_corr <= acc_div[9:0];
  end

  assign acc = 27'(s2_pp) + 27'(s2_pi) + 27'(s2_pd);

  always_comb begin
    if (acc > PD_ACC_LIM) begin
      acc_sat = PD_ACC_LIM;
    end else if (acc < -PD_ACC_LIM) begin
      acc_sat = -PD_ACC_LIM;
    end else begin
      acc_sat = acc;
    end
  end

  // Q.8 to whole us, truncating toward zero
  assign acc_div = acc_sat[26] ? ((acc_sat + 27'sd255) >>> 8) : (acc_sat >>> 8);

  assign steer_s = $signed({1'b0, STEER_CENTRE}) + 12'(s3_corr);

  always_comb begin
    rq_wdata.steer   = s3_cmd.run_pd ? steer_s[10:0] : s3_cmd.steer;
    rq_wdata.fwd     = s3_cmd.fwd;
    rq_wdata.rev     = s3_cmd.rev;
    rq_wdata.action  = s3_cmd.action;
    rq_wdata.hold    = s3_cmd.hold;
    rq_wdata.corr    = s3_cmd.run_pd ? s3_corr : 10'sd0;
    rq_wdata.filt_mm = s3_cmd.filt_mm;
    rq_wdata.dbl     = s3_cmd.dbl;
    rq_wdata.go_left = s3_cmd.go_left;
  end

  always_ff @(posedge clk) begin
    if (s3_v) begin
      rq_mem[rq_wr] <= rq_wdata;
    end
  end

  // a double word shows the stop word first, then the resume word
  assign head   = rq_mem[rq_rd];
  assign empty  = (rq_count == '0);
  assign rq_pop = pop && !empty && (!head.dbl || phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= '0;
      rq_rd    <= '0;
      rq_count <= '0;
      phase    <= 1'b0;
    end else begin
      if (s3_v) begin
        rq_wr <= rq_wr + 1'b1;
      end
      if (rq_pop) begin
        rq_rd <= rq_rd + 1'b1;
        phase <= 1'b0;
      end else if (pop && !empty) begin
        phase <= 1'b1;
      end
      rq_count <= rq_count + (RQ_AW+1)'(s3_v) - (RQ_AW+1)'(rq_pop);
    end
  end

  always_comb begin
    if (head.dbl && phase) begin
      steer_us      = head.go_left ? STEER_SOFT_LEFT : STEER_SOFT_RIGHT;
      forward_ms    = MOTOR_CREEP;
      reverse_ms    = MOTOR_OFF;
      action        = ACT_RESUME;
      hold_pause    = 1'b0;
      correction_us = 10'sd0;
    end else begin
      steer_us      = head.steer;
      forward_ms    = head.fwd;
      reverse_ms    = head.rev;
      action        = head.action;
      hold_pause    = head.hold;
      correction_us = head.corr;
    end
  end

  assign front_filtered_mm = head.filt_mm;
  assign last              = !head.dbl || phase;

endmodule

// ===== rtl/core/pd_wall_follow_obstacle_fsm_unit.sv =====
// Wall-following PD steering with front obstacle stop: top level.
// A pushed tick passes stage A, the command queue, the controller stages and the
// result queue. Throughput: one tick per cycle unless full; a stop/resume tick
// holds the output for two pops. The front filter (add and reciprocal multiply)
// loops on filt; the PD memory update loops in the controller's first stage.
// Synchronous reset restores register defaults, filter state and empties both queues.
module pd_wall_follow_obstacle_fsm_unit import pdwf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        front_raw_mm,
  input  logic [9:0]         left_echo_cm,
  input  logic [9:0]         right_echo_cm,
  output logic               empty,
  input  logic               pop,
  output logic [10:0]        steer_us,
  output logic [4:0]         forward_ms,
  output logic [4:0]         reverse_ms,
  output logic [2:0]         action,
  output logic               hold_pause,
  output logic signed [9:0]  correction_us,
  output logic [11:0]        front_filtered_mm,
  output logic               last
);

  cfg_t           cfg;
  logic           cq_push;
  cmd_t           cq_wdata;
  logic           cq_pop;
  cmd_t           cq_rdata;
  logic [CQ_AW:0] cq_count;
  logic           cq_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode           <= MODE_STRAIGHT;
      cfg.gain_p            <= 10'd179;
      cfg.gain_i            <= 10'd0;
      cfg.gain_d            <= 10'd90;
      cfg.static_stop_mm    <= 12'd250;
      cfg.dynamic_stop_mm   <= 12'd350;
      cfg.approach_limit_mm <= 12'd80;
      cfg.max_valid_mm      <= 12'd1200;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_OP_MODE:      cfg.op_mode           <= cfg_data[1:0];
        REG_GAIN_P:       cfg.gain_p            <= cfg_data[9:0];
        REG_GAIN_I:       cfg.gain_i            <= cfg_data[9:0];
        REG_GAIN_D:       cfg.gain_d            <= cfg_data[9:0];
        REG_FRONT_STOP:   cfg.static_stop_mm    <= cfg_data;
        REG_DYNAMIC_STOP: cfg.dynamic_stop_mm   <= cfg_data;
        REG_APPROACH_LIM: cfg.approach_limit_mm <= cfg_data;
        REG_MAX_VALID:    cfg.max_valid_mm      <= cfg_data;
        default: ;
      endcase
    end
  end

  pdwf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .full          (full),
    .front_raw_mm  (front_raw_mm),
    .left_echo_cm  (left_echo_cm),
    .right_echo_cm (right_echo_cm),
    .cq_count      (cq_count),
    .cq_push       (cq_push),
    .cq_wdata      (cq_wdata)
  );

  pdwf_cmd_q u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .wdata (cq_wdata),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .count (cq_count),
    .empty (cq_empty)
  );

  pdwf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cq_empty          (cq_empty),
    .cmd               (cq_rdata),
    .cq_pop            (cq_pop),
    .empty             (empty),
    .pop               (pop),
    .steer_us          (steer_us),
    .forward_ms        (forward_ms),
    .reverse_ms        (reverse_ms),
    .action            (action),
    .hold_pause        (hold_pause),
    .correction_us     (correction_us),
    .front_filtered_mm (front_filtered_mm),
    .last              (last)
  );

  a_cq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cq_push |-> (cq_count < (CQ_AW+1)'(CQ_DEPTH)) || cq_pop)
    else $error("command queue overflow");

  a_cq_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cq_pop |-> !cq_empty)
    else $error("command queue popped while empty");

  a_first_is_stop: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> (action == ACT_STOP_HOLD && hold_pause))
    else $error("non-final word is not a stop-and-hold");

  a_resume_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (!empty && last && action == ACT_RESUME))
    else $error("resume word missing after stop word");

endmodule
